@@ rtl/vpl_pkg.sv @@
// Shared constants, types and helpers for the vertex Phong lighting unit.
`timescale 1ns / 1ps

package vpl_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int INVSQRT_ITERS = 6;
   localparam int MAX_SHINE     = 255;
   localparam int SCALE_W       = 15;   // block-scaled magnitude width
   localparam int UNIT_SHIFT    = 45;   // scaled magnitude (Q.15) times y (Q2.30)
   localparam int DOT_W         = 33;
   localparam int VEC_W         = 33;

   localparam logic [31:0] NR_THREE = 32'hC000_0000;  // 3.0 in Q.30
   localparam logic [31:0] NR_Y_HI  = 32'h3000_0000;  // 0.75 in Q2.30
   localparam logic [31:0] NR_Y_LO  = 32'h5800_0000;  // 1.375 in Q2.30
   localparam logic [31:0] NR_Y_MAX = 32'h8000_0000;  // 2.0 in Q2.30

   localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;
   localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      REG_LIGHT_X   = 3'd0,
      REG_LIGHT_Y   = 3'd1,
      REG_LIGHT_Z   = 3'd2,
      REG_EYE_X     = 3'd3,
      REG_EYE_Y     = 3'd4,
      REG_EYE_Z     = 3'd5,
      REG_SHININESS = 3'd6,
      REG_LIGHT_EN  = 3'd7
   } reg_idx_type;

   // sideband carried alongside the reflection vector
   typedef struct packed {
      logic       valid;
      logic       lit;
      logic       spec_en;
      logic [7:0] diff_byte;
   } lit_tag_type;

   // sideband carried through the power chain
   typedef struct packed {
      logic       valid;
      logic       last;
      logic       lit;
      logic       spec_ok;
      logic [7:0] diff_byte;
   } out_tag_type;

   function automatic logic [31:0] pack_argb(input logic [7:0] b);
      return {8'hFF, b, b, b};
   endfunction

endpackage

@@ rtl/vpl_unit3.sv @@
// Pipelined vector normaliser: block scaling, sum of squares, Newton inverse square root.
`timescale 1ns / 1ps

module vpl_unit3 #(
   parameter int FRAC_BITS = vpl_pkg::FRAC_BITS_DEF,
   parameter int IN_W      = vpl_pkg::VEC_W,
   parameter int TAG_W     = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic signed [IN_W-1:0]      in_vec [3],
   input  logic [TAG_W-1:0]            in_tag,
   output logic signed [FRAC_BITS+1:0] out_unit [3],
   output logic                        out_ok,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int BL_W  = $clog2(IN_W + 1);
   localparam int SW    = vpl_pkg::SCALE_W;
   localparam int NCORE = 3 + 3 * vpl_pkg::INVSQRT_ITERS;
   localparam int Q_SH  = vpl_pkg::UNIT_SHIFT - FRAC_BITS;

   typedef struct {
      logic [TAG_W-1:0] tag;
      logic             neg [3];
      logic [IN_W-1:0]  mag [3];
      logic [IN_W-1:0]  mx;
      logic [BL_W-1:0]  bl;
      logic             nz;
   } front_type;

   typedef struct {
      logic [TAG_W-1:0] tag;
      logic             nz;
      logic             neg [3];
      logic [SW-1:0]    sm [3];
      logic [2*SW-1:0]  sq [3];
      logic [2*SW+1:0]  s;
      logic [31:0]      y;
      logic [32:0]      aux;
   } core_type;

   typedef struct {
      logic [TAG_W-1:0]            tag;
      logic                        ok;
      logic signed [FRAC_BITS+1:0] unit [3];
   } res_type;

   front_type a_in, a_ff, b_in, b_ff, c_in, c_ff;
   core_type  core_in [NCORE];
   core_type  core_ff [NCORE];
   res_type   res_in, res_ff;

   // magnitudes and signs
   always_comb begin
      a_in.tag = in_tag;
      a_in.mx  = '0;
      a_in.bl  = '0;
      a_in.nz  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = in_vec[i][IN_W-1];
         a_in.mag[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
      end
   end

   // largest magnitude
   always_comb begin
      b_in    = a_ff;
      b_in.mx = a_ff.mag[0];
      if (a_ff.mag[1] > b_in.mx) b_in.mx = a_ff.mag[1];
      if (a_ff.mag[2] > b_in.mx) b_in.mx = a_ff.mag[2];
   end

   // bit length of the largest magnitude
   always_comb begin
      c_in    = b_ff;
      c_in.nz = |b_ff.mx;
      c_in.bl = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (b_ff.mx[i]) c_in.bl = BL_W'(i + 1);
      end
   end

   always_comb begin
      logic [64:0] sy;
      logic [34:0] a;
      logic [63:0] yy;
      logic [63:0] yt;
      logic [31:0] yn;

      // scale so that the largest magnitude lies in [2^14, 2^15)
      core_in[0].tag = c_ff.tag;
      core_in[0].nz  = c_ff.nz;
      core_in[0].s   = '0;
      core_in[0].y   = '0;
      core_in[0].aux = '0;
      for (int i = 0; i < 3; i++) begin
         core_in[0].neg[i] = c_ff.neg[i];
         core_in[0].sq[i]  = '0;
         if (c_ff.bl > BL_W'(SW)) begin
            core_in[0].sm[i] = SW'(c_ff.mag[i] >> (c_ff.bl - BL_W'(SW)));
         end else begin
            core_in[0].sm[i] = SW'(c_ff.mag[i] << (BL_W'(SW) - c_ff.bl));
         end
      end

      // squares
      core_in[1] = core_ff[0];
      for (int i = 0; i < 3; i++) begin
         core_in[1].sq[i] = (2*SW)'(core_ff[0].sm[i]) * (2*SW)'(core_ff[0].sm[i]);
      end

      // sum and starting estimate
      core_in[2]   = core_ff[1];
      core_in[2].s = (2*SW+2)'(core_ff[1].sq[0]) + (2*SW+2)'(core_ff[1].sq[1])
                   + (2*SW+2)'(core_ff[1].sq[2]);
      core_in[2].y = (core_in[2].s[2*SW+1:2*SW] != 2'b00) ? vpl_pkg::NR_Y_HI
                                                          : vpl_pkg::NR_Y_LO;

      // Newton steps, three stages each
      for (int k = 0; k < vpl_pkg::INVSQRT_ITERS; k++) begin
         yy = 64'(core_ff[3*k+2].y) * 64'(core_ff[3*k+2].y);
         core_in[3*k+3]     = core_ff[3*k+2];
         core_in[3*k+3].aux = yy[62:30];

         sy = 65'(core_ff[3*k+3].s) * 65'(core_ff[3*k+3].aux);
         a  = sy[64:30];
         core_in[3*k+4]     = core_ff[3*k+3];
         core_in[3*k+4].aux = (a >= 35'(vpl_pkg::NR_THREE)) ? '0
                              : 33'(35'(vpl_pkg::NR_THREE) - a);

         yt = 64'(core_ff[3*k+4].y) * 64'(core_ff[3*k+4].aux[31:0]);
         yn = yt[62:31];
         core_in[3*k+5]   = core_ff[3*k+4];
         core_in[3*k+5].y = (yn > vpl_pkg::NR_Y_MAX) ? vpl_pkg::NR_Y_MAX : yn;
      end
   end

   // unit components, sign applied after truncation
   always_comb begin
      logic [SW+31:0]              mq;
      logic signed [FRAC_BITS+1:0] qs;
      res_in.tag = core_ff[NCORE-1].tag;
      res_in.ok  = core_ff[NCORE-1].nz;
      for (int i = 0; i < 3; i++) begin
         mq = (SW+32)'(core_ff[NCORE-1].sm[i]) * (SW+32)'(core_ff[NCORE-1].y);
         qs = $signed((FRAC_BITS+2)'(mq >> Q_SH));
         res_in.unit[i] = core_ff[NCORE-1].neg[i] ? -qs : qs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.tag   <= '0;
         b_ff.tag   <= '0;
         c_ff.tag   <= '0;
         res_ff.tag <= '0;
         for (int j = 0; j < NCORE; j++) begin
            core_ff[j].tag <= '0;
         end
      end else if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         res_ff <= res_in;
         for (int j = 0; j < NCORE; j++) begin
            core_ff[j] <= core_in[j];
         end
      end
   end

   assign out_unit = res_ff.unit;
   assign out_ok   = res_ff.ok;
   assign out_tag  = res_ff.tag;

endmodule

@@ rtl/vpl_power.sv @@
// Specular power chain: one truncating multiply stage per unit of shininess.
`timescale 1ns / 1ps

module vpl_power #(
   parameter int FRAC_BITS = vpl_pkg::FRAC_BITS_DEF,
   parameter int TAG_W     = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [7:0]           shine,
   input  logic [FRAC_BITS:0]   in_dd,
   input  logic [TAG_W-1:0]     in_tag,
   output logic [FRAC_BITS:0]   out_p,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int NSTEP = vpl_pkg::MAX_SHINE;
   localparam logic [FRAC_BITS:0] ONE1 = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0] p_src  [NSTEP];
   logic [FRAC_BITS:0] dd_src [NSTEP];
   logic [TAG_W-1:0]   tag_src [NSTEP];
   logic [FRAC_BITS:0] p_in   [NSTEP];
   logic [FRAC_BITS:0] p_ff   [NSTEP];
   logic [FRAC_BITS:0] dd_ff  [NSTEP];
   logic [TAG_W-1:0]   tag_ff [NSTEP];

   always_comb begin
      p_src[0]   = ONE1;
      dd_src[0]  = in_dd;
      tag_src[0] = in_tag;
      for (int k = 1; k < NSTEP; k++) begin
         p_src[k]   = p_ff[k-1];
         dd_src[k]  = dd_ff[k-1];
         tag_src[k] = tag_ff[k-1];
      end
   end

   // stage k multiplies only while k is below the exponent
   always_comb begin
      logic [2*FRAC_BITS+1:0] m;
      for (int k = 0; k < NSTEP; k++) begin
         m = (2*FRAC_BITS+2)'(p_src[k]) * (2*FRAC_BITS+2)'(dd_src[k]);
         p_in[k] = (8'(k) < shine) ? (FRAC_BITS+1)'(m >> FRAC_BITS) : p_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTEP; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (en) begin
         for (int k = 0; k < NSTEP; k++) begin
            p_ff[k]   <= p_in[k];
            dd_ff[k]  <= dd_src[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign out_p   = p_ff[NSTEP-1];
   assign out_tag = tag_ff[NSTEP-1];

endmodule

@@ rtl/vertex_phong_lighting_unit.sv @@
// Top level of the per-vertex monochrome Phong lighting pipeline.
`timescale 1ns / 1ps

// Usage:
//   Requests come in on req_* (normal in Q2.14, position in Q16.16, tlast marks the
//   last vertex of an object); results leave on rsp_* as two ARGB words.
//   Registers are written through csr_we/csr_addr/csr_wdata while no request is in
//   flight; each write lands on the clock edge where csr_we is high.
//   Throughput: one request per cycle, sustained while the result channel is not stalled.
//   Pipeline: the bulk of the path from request acceptance to rsp_tvalid is the
//   255-stage specular power chain (one multiply per stage, shininess up to 255),
//   then each vector normaliser (six Newton steps, three stages each),
//   the front end (dot product, diffuse, reflection) and the output register.
//   Stall: the whole pipeline advances only while the output register is empty or
//   being taken, and req_tready is that same condition; a held result keeps every stage
//   frozen and nothing is dropped or repeated.
//   Reset: synchronous, clears all valid bits and loads the register defaults
//   (light along +z, eye at origin, shininess 8, lighting enabled).
//   With lighting disabled the result is white diffuse and black specular.

module vertex_phong_lighting_unit #(
   parameter int FRAC_BITS = vpl_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // normal_x, normal_y, normal_z, vert_x, vert_y, vert_z
   input  logic         req_tlast,   // last_vertex
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // diffuse_argb, specular_argb
   output logic         rsp_tlast,   // last_out
   // register write port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int D_W   = 2*FRAC_BITS + 1;
   localparam int PR_W  = vpl_pkg::DOT_W + 16;
   localparam int R_W   = ((2*FRAC_BITS + 16 > PR_W + 1) ? 2*FRAC_BITS + 16 : PR_W + 1) + 1;
   localparam int U_W   = FRAC_BITS + 2;
   localparam int UP_W  = 2*FRAC_BITS + 4;
   localparam int RV_W  = 2*FRAC_BITS + 6;
   localparam int LT_W  = $bits(vpl_pkg::lit_tag_type);
   localparam int OT_W  = $bits(vpl_pkg::out_tag_type);
   localparam logic [FRAC_BITS:0] ONE1  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [D_W-1:0]     ONE2  = {1'b1, {(2*FRAC_BITS){1'b0}}};
   localparam logic [D_W-1:0]     TENTH =
      D_W'(((64'd1 << (2*FRAC_BITS)) + 64'd5) / 64'd10);

   typedef struct {
      logic               valid;
      logic               last;
      logic signed [15:0] n [3];
      logic signed [31:0] vert [3];
   } st0_type;

   typedef struct {
      logic                             valid;
      logic                             last;
      logic signed [15:0]               n [3];
      logic signed [31:0]               nl [3];
      logic signed [vpl_pkg::VEC_W-1:0] v [3];
   } st1_type;

   typedef struct {
      logic                             valid;
      logic                             last;
      logic signed [15:0]               n [3];
      logic signed [vpl_pkg::DOT_W-1:0] dot;
      logic signed [vpl_pkg::VEC_W-1:0] v [3];
   } st2_type;

   typedef struct {
      logic                             valid;
      logic                             last;
      logic                             spec_en;
      logic [D_W-1:0]                   d;
      logic signed [PR_W-1:0]           prod [3];
      logic signed [vpl_pkg::VEC_W-1:0] v [3];
   } st3_type;

   typedef struct {
      logic                             valid;
      logic                             last;
      logic                             lit;
      logic                             spec_en;
      logic [7:0]                       diff_byte;
      logic signed [R_W-1:0]            r [3];
      logic signed [vpl_pkg::VEC_W-1:0] v [3];
   } st4_type;

   typedef struct {
      vpl_pkg::out_tag_type   tag;
      logic signed [UP_W-1:0] pr [3];
   } st5_type;

   typedef struct {
      vpl_pkg::out_tag_type tag;
      logic [FRAC_BITS:0]   dd;
   } st6_type;

   // configuration registers
   logic signed [15:0] light_in [3];
   logic signed [15:0] light_ff [3];
   logic signed [31:0] eye_in [3];
   logic signed [31:0] eye_ff [3];
   logic [7:0]         shine_in, shine_ff;
   logic               lit_en_in, lit_en_ff;

   logic adv;

   st0_type st0_in, st0_ff;
   st1_type st1_in, st1_ff;
   st2_type st2_in, st2_ff;
   st3_type st3_in, st3_ff;
   st4_type st4_in, st4_ff;
   st5_type st5_in, st5_ff;
   st6_type st6_in, st6_ff;

   vpl_pkg::lit_tag_type r_tag, r_tag_o;
   logic signed [U_W-1:0] ru [3];
   logic signed [U_W-1:0] vu [3];
   logic                  r_ok, v_ok, v_last;

   vpl_pkg::out_tag_type  pow_tag;
   logic [FRAC_BITS:0]    pow_p;

   logic        rsp_tvalid_in, rsp_tvalid_ff;
   logic [63:0] rsp_tdata_in, rsp_tdata_ff;
   logic        rsp_tlast_in, rsp_tlast_ff;

   // advance everything while the output register can take a result
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // register writes, truncated to each register's width
   always_comb begin
      light_in  = light_ff;
      eye_in    = eye_ff;
      shine_in  = shine_ff;
      lit_en_in = lit_en_ff;
      if (csr_we) begin
         unique case (vpl_pkg::reg_idx_type'(csr_addr))
            vpl_pkg::REG_LIGHT_X:   light_in[0] = csr_wdata[15:0];
            vpl_pkg::REG_LIGHT_Y:   light_in[1] = csr_wdata[15:0];
            vpl_pkg::REG_LIGHT_Z:   light_in[2] = csr_wdata[15:0];
            vpl_pkg::REG_EYE_X:     eye_in[0]   = csr_wdata;
            vpl_pkg::REG_EYE_Y:     eye_in[1]   = csr_wdata;
            vpl_pkg::REG_EYE_Z:     eye_in[2]   = csr_wdata;
            vpl_pkg::REG_SHININESS: shine_in    = csr_wdata[7:0];
            vpl_pkg::REG_LIGHT_EN:  lit_en_in   = csr_wdata[0];
            default:                lit_en_in   = lit_en_ff;
         endcase
      end
   end

   // capture the request
   always_comb begin
      st0_in.valid   = req_tvalid;
      st0_in.last    = req_tlast;
      st0_in.n[0]    = req_tdata[15:0];
      st0_in.n[1]    = req_tdata[31:16];
      st0_in.n[2]    = req_tdata[47:32];
      st0_in.vert[0] = req_tdata[79:48];
      st0_in.vert[1] = req_tdata[111:80];
      st0_in.vert[2] = req_tdata[143:112];
   end

   // N.L partial products and the view vector E - P
   always_comb begin
      st1_in.valid = st0_ff.valid;
      st1_in.last  = st0_ff.last;
      st1_in.n     = st0_ff.n;
      for (int i = 0; i < 3; i++) begin
         st1_in.nl[i] = 32'(st0_ff.n[i]) * 32'(light_ff[i]);
         st1_in.v[i]  = vpl_pkg::VEC_W'(eye_ff[i]) - vpl_pkg::VEC_W'(st0_ff.vert[i]);
      end
   end

   // N.L, exact in Q.2F
   always_comb begin
      st2_in.valid = st1_ff.valid;
      st2_in.last  = st1_ff.last;
      st2_in.n     = st1_ff.n;
      st2_in.v     = st1_ff.v;
      st2_in.dot   = vpl_pkg::DOT_W'(st1_ff.nl[0]) + vpl_pkg::DOT_W'(st1_ff.nl[1])
                   + vpl_pkg::DOT_W'(st1_ff.nl[2]);
   end

   // diffuse clamp plus ambient, and (N.L) N for the reflection
   always_comb begin
      logic [63:0]  dpos;
      logic [D_W-1:0] dc;
      logic [D_W:0]   dsum;
      st3_in.valid   = st2_ff.valid;
      st3_in.last    = st2_ff.last;
      st3_in.v       = st2_ff.v;
      st3_in.spec_en = !st2_ff.dot[vpl_pkg::DOT_W-1];
      dpos = 64'($unsigned(st2_ff.dot));
      if (st2_ff.dot[vpl_pkg::DOT_W-1]) begin
         dc = '0;
      end else if (dpos > 64'(ONE2)) begin
         dc = ONE2;
      end else begin
         dc = D_W'(dpos);
      end
      dsum     = (D_W+1)'(dc) + (D_W+1)'(TENTH);
      st3_in.d = (dsum > (D_W+1)'(ONE2)) ? ONE2 : D_W'(dsum);
      for (int i = 0; i < 3; i++) begin
         st3_in.prod[i] = PR_W'(st2_ff.dot) * PR_W'(st2_ff.n[i]);
      end
   end

   // reflection R = 2(N.L)N - L in Q.3F, diffuse byte
   always_comb begin
      logic [D_W+7:0] dm;
      st4_in.valid   = st3_ff.valid;
      st4_in.last    = st3_ff.last;
      st4_in.lit     = lit_en_ff;
      st4_in.spec_en = st3_ff.spec_en;
      st4_in.v       = st3_ff.v;
      dm = (D_W+8)'(st3_ff.d) * (D_W+8)'(8'd255);
      st4_in.diff_byte = 8'(dm >> (2*FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
         st4_in.r[i] = (R_W'(st3_ff.prod[i]) <<< 1)
                     - (R_W'(light_ff[i]) <<< (2*FRAC_BITS));
      end
   end

   always_comb begin
      r_tag.valid     = st4_ff.valid;
      r_tag.lit       = st4_ff.lit;
      r_tag.spec_en   = st4_ff.spec_en;
      r_tag.diff_byte = st4_ff.diff_byte;
   end

   vpl_unit3 #(
      .FRAC_BITS (FRAC_BITS),
      .IN_W      (R_W),
      .TAG_W     (LT_W)
   ) u_norm_r (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vec   (st4_ff.r),
      .in_tag   (r_tag),
      .out_unit (ru),
      .out_ok   (r_ok),
      .out_tag  (r_tag_o)
   );

   vpl_unit3 #(
      .FRAC_BITS (FRAC_BITS),
      .IN_W      (vpl_pkg::VEC_W),
      .TAG_W     (1)
   ) u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vec   (st4_ff.v),
      .in_tag   (st4_ff.last),
      .out_unit (vu),
      .out_ok   (v_ok),
      .out_tag  (v_last)
   );

   // R.V partial products; a zero-length vector kills the specular term
   always_comb begin
      st5_in.tag.valid     = r_tag_o.valid;
      st5_in.tag.last      = v_last;
      st5_in.tag.lit       = r_tag_o.lit;
      st5_in.tag.spec_ok   = r_tag_o.spec_en && r_ok && v_ok;
      st5_in.tag.diff_byte = r_tag_o.diff_byte;
      for (int i = 0; i < 3; i++) begin
         st5_in.pr[i] = UP_W'(ru[i]) * UP_W'(vu[i]);
      end
   end

   // R.V down to Q.F, clamped to [0, 1.0]
   always_comb begin
      logic signed [RV_W-1:0] rv;
      logic signed [RV_W-1:0] rs;
      st6_in.tag = st5_ff.tag;
      rv = RV_W'(st5_ff.pr[0]) + RV_W'(st5_ff.pr[1]) + RV_W'(st5_ff.pr[2]);
      rs = rv >>> FRAC_BITS;
      if (rv[RV_W-1]) begin
         st6_in.dd = '0;
      end else if (rs > RV_W'(ONE1)) begin
         st6_in.dd = ONE1;
      end else begin
         st6_in.dd = (FRAC_BITS+1)'(rs);
      end
   end

   vpl_power #(
      .FRAC_BITS (FRAC_BITS),
      .TAG_W     (OT_W)
   ) u_power (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .shine   (shine_ff),
      .in_dd   (st6_ff.dd),
      .in_tag  (st6_ff.tag),
      .out_p   (pow_p),
      .out_tag (pow_tag)
   );

   // pack both terms; disabled lighting gives white diffuse, black specular
   always_comb begin
      logic [FRAC_BITS+8:0] sm;
      logic [7:0]           sb;
      sm = (FRAC_BITS+9)'(pow_p) * (FRAC_BITS+9)'(8'd255);
      sb = 8'(sm >> FRAC_BITS);
      rsp_tvalid_in = pow_tag.valid;
      rsp_tlast_in  = pow_tag.last;
      rsp_tdata_in[31:0]  = pow_tag.lit ? vpl_pkg::pack_argb(pow_tag.diff_byte)
                                        : vpl_pkg::ARGB_WHITE;
      rsp_tdata_in[63:32] = (pow_tag.lit && pow_tag.spec_ok) ? vpl_pkg::pack_argb(sb)
                                                             : vpl_pkg::ARGB_BLACK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0]   <= '0;
         light_ff[1]   <= '0;
         light_ff[2]   <= 16'(ONE1);
         eye_ff[0]     <= '0;
         eye_ff[1]     <= '0;
         eye_ff[2]     <= '0;
         shine_ff      <= 8'd8;
         lit_en_ff     <= 1'b1;
      end else begin
         light_ff      <= light_in;
         eye_ff        <= eye_in;
         shine_ff      <= shine_in;
         lit_en_ff     <= lit_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_ff.valid     <= 1'b0;
         st1_ff.valid     <= 1'b0;
         st2_ff.valid     <= 1'b0;
         st3_ff.valid     <= 1'b0;
         st4_ff.valid     <= 1'b0;
         st5_ff.tag.valid <= 1'b0;
         st6_ff.tag.valid <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
      end else if (adv) begin
         st0_ff        <= st0_in;
         st1_ff        <= st1_in;
         st2_ff        <= st2_in;
         st3_ff        <= st3_in;
         st4_ff        <= st4_in;
         st5_ff        <= st5_in;
         st6_ff        <= st6_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tdata_ff  <= rsp_tdata_in;
         rsp_tlast_ff  <= rsp_tlast_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the vertex Phong lighting unit.
`timescale 1ns / 1ps

module testbench;

   localparam int FB = 14;
   localparam int LATENCY = 288;

   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic signed [31:0] px, py, pz;
      logic               last;
   } vertex_type;

   typedef struct {
      logic [31:0] diffuse;
      logic [31:0] specular;
      logic        last;
   } shade_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = vpl_pkg::REG_LIGHT_X;
   logic [31:0]  csr_wdata = '0;

   // shadow copy of the register file
   logic signed [15:0] lx, ly, lz;
   logic signed [31:0] ex, ey, ez;
   logic [7:0]         shine;
   logic               lit_en;

   vertex_type pending_vertices[$];
   shade_type  expected_shades[$];
   int         mismatches = 0;
   int         shades_seen = 0;

   vertex_phong_lighting_unit dut (.*);

   always #10 clock = ~clock;

   // Normalise a vector the way the block does; returns 0 for a zero vector.
   function automatic bit normalise(input longint v[3], output longint u[3]);
      longint unsigned m[3], mx, t, s, y, y2, a, term;
      bit neg[3];
      int bl;
      mx = 0; bl = 0; s = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         m[i] = neg[i] ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 0;
      for (t = mx; t != 0; t >>= 1) bl++;
      for (int i = 0; i < 3; i++) begin
         if (bl > 15) m[i] >>= (bl - 15);
         else m[i] <<= (15 - bl);
         s += m[i] * m[i];
      end
      y = (s >= 64'd1 << 30) ? 64'd3 << 28 : 64'd11 << 27;
      for (int k = 0; k < 6; k++) begin
         y2 = (y * y) >> 30;
         a = (s * y2) >> 30;
         term = (a >= 64'd3 << 30) ? 0 : (64'd3 << 30) - a;
         y = (y * term) >> 31;
         if (y > 64'd1 << 31) y = 64'd1 << 31;
      end
      for (int i = 0; i < 3; i++) begin
         t = (m[i] * y) >> (45 - FB);
         u[i] = neg[i] ? -longint'(t) : longint'(t);
      end
      return 1;
   endfunction

   function automatic shade_type shade_vertex(input vertex_type vx);
      shade_type sh;
      longint n[3], l[3], r[3], v[3], ru[3], vu[3], dotp, rv;
      longint unsigned one2, d, dd, p, sb;
      sh.last = vx.last;
      if (!lit_en) begin
         sh.diffuse = vpl_pkg::ARGB_WHITE;
         sh.specular = vpl_pkg::ARGB_BLACK;
         return sh;
      end
      one2 = 64'd1 << (2 * FB);
      n = '{vx.nx, vx.ny, vx.nz};
      l = '{lx, ly, lz};
      dotp = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      d = (dotp < 0) ? 0 : dotp;
      if (d > one2) d = one2;
      d += (one2 + 5) / 10;
      if (d > one2) d = one2;
      sh.diffuse = {8'hFF, {3{8'((d * 255) >> (2 * FB))}}};
      sb = 0;
      if (dotp >= 0) begin
         v = '{longint'(ex) - vx.px, longint'(ey) - vx.py, longint'(ez) - vx.pz};
         for (int i = 0; i < 3; i++) r[i] = 2 * dotp * n[i] - (l[i] <<< (2 * FB));
         if (normalise(r, ru) && normalise(v, vu)) begin
            rv = ru[0] * vu[0] + ru[1] * vu[1] + ru[2] * vu[2];
            dd = (rv < 0) ? 0 : ($unsigned(rv) >> FB);
            if (dd > 64'd1 << FB) dd = 64'd1 << FB;
            p = 64'd1 << FB;
            for (int k = 0; k < shine; k++) p = (p * dd) >> FB;
            sb = (p * 255) >> FB;
         end
      end
      sh.specular = {8'hFF, {3{8'(sb)}}};
      return sh;
   endfunction

   // Driver: present pending requests, with a random gap after each one is taken.
   int gap_cnt = 0;
   bit req_taken;
   always @(posedge clock) req_taken <= req_tvalid && req_tready && !reset;

   always @(negedge clock) begin
      vertex_type vx;
      if (!reset) begin
         if (req_taken || !req_tvalid) begin
            if (req_taken) begin
               expected_shades.push_back(shade_vertex(pending_vertices.pop_front()));
               gap_cnt = $urandom_range(0, 4);
            end
            if (gap_cnt > 0 || pending_vertices.size() == 0) begin
               if (gap_cnt > 0) gap_cnt--;
               req_tvalid <= 1'b0;
            end else begin
               vx = pending_vertices[0];
               req_tdata <= {vx.pz, vx.py, vx.px, vx.nz, vx.ny, vx.nx};
               req_tlast <= vx.last;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Receiver: hold ready low for a random number of cycles after each result.
   int rsp_gap = 0;
   bit rsp_taken;
   always @(posedge clock) rsp_taken <= rsp_tvalid && rsp_tready && !reset;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_gap = $urandom_range(0, 4);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      shade_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         shades_seen++;
         if (expected_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = expected_shades.pop_front();
            if (rsp_tdata[31:0] !== want.diffuse || rsp_tdata[63:32] !== want.specular ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: diffuse %h/%h specular %h/%h last %b/%b",
                           want.diffuse, rsp_tdata[31:0], want.specular,
                           rsp_tdata[63:32], want.last, rsp_tlast);
            end
         end
      end
   end

   task automatic write_reg(input vpl_pkg::reg_idx_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         vpl_pkg::REG_LIGHT_X:   lx = val[15:0];
         vpl_pkg::REG_LIGHT_Y:   ly = val[15:0];
         vpl_pkg::REG_LIGHT_Z:   lz = val[15:0];
         vpl_pkg::REG_EYE_X:     ex = val;
         vpl_pkg::REG_EYE_Y:     ey = val;
         vpl_pkg::REG_EYE_Z:     ez = val;
         vpl_pkg::REG_SHININESS: shine = val[7:0];
         default:                lit_en = val[0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for the pipeline to drain before touching registers.
   task automatic drain();
      wait (pending_vertices.size() == 0 && !req_tvalid && expected_shades.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic queue_vertex(input logic [15:0] nx, ny, nz, input logic [31:0] px, py, pz,
                               input logic last);
      vertex_type vx;
      vx.nx = nx; vx.ny = ny; vx.nz = nz;
      vx.px = px; vx.py = py; vx.pz = pz;
      vx.last = last;
      pending_vertices.push_back(vx);
   endtask

   // Random unit-ish normal; mostly well-formed, some raw noise.
   function automatic logic [15:0] rand_comp(input bit wild);
      return wild ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
   endfunction

   function automatic logic [31:0] rand_pos(input bit wild);
      return wild ? $urandom : 32'($urandom_range(0, 20 << 16)) - (32'd10 << 16);
   endfunction

   task automatic random_phase(input int count);
      bit wild;
      for (int i = 0; i < count; i++) begin
         wild = ($urandom_range(0, 4) == 0);
         queue_vertex(rand_comp(wild), rand_comp(wild), rand_comp(wild),
                      rand_pos(wild), rand_pos(wild), rand_pos(wild), $urandom_range(0, 1));
      end
      drain();
   endtask

   initial begin
      lx = 0; ly = 0; lz = 16'sd16384; ex = 0; ey = 0; ez = 0; shine = 8; lit_en = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, field extremes and the special cases.
      queue_vertex(16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'h0010_0000, 1'b0);
      queue_vertex(16'sd0, 16'sd0, -16'sd16384, 0, 0, 32'h0010_0000, 1'b1);       // N.L < 0
      queue_vertex(16'sd0, 16'sd0, 16'sd16384, 0, 0, 0, 1'b0);                    // V zero
      queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 1'b1);
      queue_vertex(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 1'b0);
      queue_vertex(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000, 1'b1);
      queue_vertex(16'sd11585, 16'sd0, 16'sd11585, 0, 0, 32'h0004_0000, 1'b0);
      queue_vertex(16'hFFFF, 16'h0001, 16'h7FFF, 32'h1, 32'h0, 32'h8000_0000, 1'b1);
      drain();

      // Zero-length R: normal perpendicular to the light, light itself zero.
      write_reg(vpl_pkg::REG_LIGHT_Z, 32'd0);
      write_reg(vpl_pkg::REG_SHININESS, 32'd0);
      queue_vertex(16'sd0, 16'sd0, 16'sd16384, 0, 0, 32'h0001_0000, 1'b0);
      drain();
      write_reg(vpl_pkg::REG_LIGHT_X, 32'h0000_8000);
      write_reg(vpl_pkg::REG_LIGHT_Y, 32'h0000_7FFF);
      write_reg(vpl_pkg::REG_LIGHT_Z, 32'h0000_8000);
      write_reg(vpl_pkg::REG_EYE_X, 32'h7FFF_FFFF);
      write_reg(vpl_pkg::REG_EYE_Y, 32'h8000_0000);
      write_reg(vpl_pkg::REG_EYE_Z, 32'hFFFF_FFFF);
      write_reg(vpl_pkg::REG_SHININESS, 32'd255);
      queue_vertex(16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 1'b1);
      queue_vertex(16'sd16384, 16'sd0, 16'sd0, 32'h7FFF_FFFF, 0, 0, 1'b0);
      drain();
      write_reg(vpl_pkg::REG_LIGHT_EN, 32'd0);
      queue_vertex(16'sd0, 16'sd0, 16'sd16384, 0, 0, 32'h0010_0000, 1'b1);
      queue_vertex(16'h7FFF, 16'h8000, 16'h0, 32'h1234_5678, 0, 0, 1'b0);
      drain();

      // Random phases over several register settings.
      write_reg(vpl_pkg::REG_LIGHT_EN, 32'd1);
      write_reg(vpl_pkg::REG_LIGHT_X, 32'd0);
      write_reg(vpl_pkg::REG_LIGHT_Y, 32'd0);
      write_reg(vpl_pkg::REG_LIGHT_Z, 32'd16384);
      write_reg(vpl_pkg::REG_EYE_X, 32'd0);
      write_reg(vpl_pkg::REG_EYE_Y, 32'd0);
      write_reg(vpl_pkg::REG_EYE_Z, 32'h0020_0000);
      write_reg(vpl_pkg::REG_SHININESS, 32'd8);
      random_phase(300);
      write_reg(vpl_pkg::REG_LIGHT_X, 32'd9459);
      write_reg(vpl_pkg::REG_LIGHT_Y, 32'd9459);
      write_reg(vpl_pkg::REG_LIGHT_Z, 32'd9459);
      write_reg(vpl_pkg::REG_SHININESS, 32'd1);
      random_phase(250);
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(vpl_pkg::REG_LIGHT_X, $urandom);
         write_reg(vpl_pkg::REG_LIGHT_Y, $urandom);
         write_reg(vpl_pkg::REG_LIGHT_Z, $urandom);
         write_reg(vpl_pkg::REG_EYE_X, $urandom);
         write_reg(vpl_pkg::REG_EYE_Y, $urandom);
         write_reg(vpl_pkg::REG_EYE_Z, $urandom);
         write_reg(vpl_pkg::REG_SHININESS, $urandom_range(0, 255));
         write_reg(vpl_pkg::REG_LIGHT_EN, ($urandom_range(0, 5) != 0));
         random_phase(130);
      end

      $display("checked %0d results: directed corner cases, lighting switched off,",
               shades_seen);
      $display("and random vertices under several random register settings");
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("testbench: FAIL");
      $finish;
   end

endmodule
